@@ rtl/firlt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firlt_pkg: shared types and constants for the loadable-tap FIR filter
// Sizes of the coefficient and history stores, datapath widths, item kinds,
// sequencer states and the control bundle of the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package firlt_pkg;

  localparam int MAX_TAPS    = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + $clog2(MAX_TAPS);

  localparam int CFG_W       = 9;
  localparam int INDEX_W     = 8;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } seq_state_t;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctl_t;

endpackage

@@ rtl/firlt_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firlt_mac: shared multiply-accumulate unit
// Registers one sample-by-tap product per enabled cycle, then adds it into a
// wide accumulator. Clear zeroes the accumulator at the start of a sample.
// ----------------------------------------------------------------------------
module firlt_mac
  import firlt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  mac_ctl_t                      ctl,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic signed [SAMPLE_BITS-1:0] b,
  output logic signed [ACC_W-1:0]       acc,
  output logic                          busy
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod <= a * b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = prod_vld;

endmodule

@@ rtl/firlt_sat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firlt_sat: round and saturate the accumulator to sample width
// Round to nearest with ties toward plus infinity, then clamp to the
// signed sample range and flag any clamping.
// ----------------------------------------------------------------------------
module firlt_sat
  import firlt_pkg::*;
(
  input  logic signed [ACC_W-1:0]       acc,
  output logic signed [SAMPLE_BITS-1:0] filtered,
  output logic                          clipped
);

  localparam int RND_W = ACC_W + 1;
  localparam int SH_W  = RND_W - (SAMPLE_BITS - 1);

  logic signed [RND_W-1:0] rnd;
  logic signed [SH_W-1:0]  shifted;
  logic [SH_W-SAMPLE_BITS:0] upper;
  logic                    sign;

  always_comb begin
    rnd      = RND_W'(acc) + RND_W'(signed'({1'b0, 1'b1, {(SAMPLE_BITS - 2){1'b0}}}));
    shifted  = SH_W'(rnd >>> (SAMPLE_BITS - 1));
    upper    = shifted[SH_W-1:SAMPLE_BITS-1];
    sign     = shifted[SH_W-1];
    clipped  = !((&upper) || !(|upper));
    if (clipped) begin
      filtered = {sign, {(SAMPLE_BITS - 1){~sign}}};
    end else begin
      filtered = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule

@@ rtl/fir_filter_loadable_taps_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_loadable_taps_top: direct-form FIR filter with loadable taps
// Channel | Handshake          | Carries
// in      | in_valid/in_ready  | kind, tap_index, tap_value, sample, restart
// out     | out_valid/out_ready| filtered, clipped
// cfg     | cfg_we             | cfg_data (taps in use)
// A load transaction writes one coefficient store entry. A sample transaction
// runs min(taps_used, 256) taps, none when no taps are in use: one tap per
// cycle through the single multiply-accumulate unit, fed by one read port on
// each store.
// Reset clears the history valid bits at once; no clearing pass is needed.
// A finished result waits in the output register; the next transaction is
// taken meanwhile, but a later result holds until the register is free.
// ----------------------------------------------------------------------------
module fir_filter_loadable_taps_top
  import firlt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [INDEX_W-1:0]            tap_index,
  input  logic signed [SAMPLE_BITS-1:0] tap_value,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] filtered,
  output logic                          clipped,
  input  logic                          cfg_we,
  input  logic [CFG_W-1:0]              cfg_data
);

  seq_state_t state, state_next;

  logic [CFG_W-1:0]     taps_used;
  logic [TAP_CNT_W-1:0] n_taps;
  logic [TAP_CNT_W-1:0] tap_cnt;
  logic [TAP_IDX_W-1:0] slot;
  logic [TAP_IDX_W-1:0] newest;
  logic [TAP_IDX_W-1:0] base_slot;
  logic [TAP_IDX_W-1:0] new_slot;
  logic [MAX_TAPS-1:0]  hist_ok, hist_ok_next;
  logic                 rd_vld;

  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] coef_q;
  logic signed [SAMPLE_BITS-1:0] hist_q;
  logic                          hist_ok_q;
  logic signed [SAMPLE_BITS-1:0] mac_a;

  logic accept, accept_load, accept_sample;
  logic issue, drain_done, out_load;

  mac_ctl_t                      mac_ctl;
  logic signed [ACC_W-1:0]       acc;
  logic                          mac_busy;
  logic signed [SAMPLE_BITS-1:0] sat_value;
  logic                          sat_clip;

  assign accept        = in_valid && in_ready;
  assign accept_load   = accept && (kind == KIND_LOAD);
  assign accept_sample = accept && (kind == KIND_SAMPLE);

  always_comb begin
    base_slot = restart ? '0 : newest;
    if (int'(base_slot) == MAX_TAPS - 1) begin
      new_slot = '0;
    end else begin
      new_slot = base_slot + 1'b1;
    end
  end

  always_comb begin
    hist_ok_next = hist_ok;
    if (accept_sample) begin
      if (restart) begin
        hist_ok_next = '0;
      end
      hist_ok_next[new_slot] = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept_sample) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (tap_cnt == n_taps) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    issue         = 1'b0;
    drain_done    = 1'b0;
    out_load      = 1'b0;
    mac_ctl.clear = accept_sample;
    mac_ctl.en    = rd_vld;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_RUN: begin
        issue = (tap_cnt != n_taps);
      end
      S_DRAIN: begin
        drain_done = !rd_vld && !mac_busy;
        out_load   = drain_done && (!out_valid || out_ready);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      taps_used <= CFG_W'(1);
      n_taps    <= '0;
      tap_cnt   <= '0;
      slot      <= '0;
      newest    <= '0;
      hist_ok   <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      hist_ok <= hist_ok_next;
      rd_vld  <= issue;
      if (cfg_we) begin
        taps_used <= cfg_data;
      end
      if (accept_sample) begin
        newest  <= new_slot;
        slot    <= new_slot;
        tap_cnt <= '0;
        if (int'(taps_used) > MAX_TAPS) begin
          n_taps <= TAP_CNT_W'(MAX_TAPS);
        end else begin
          n_taps <= TAP_CNT_W'(taps_used);
        end
      end else if (issue) begin
        tap_cnt <= tap_cnt + 1'b1;
        if (slot == '0) begin
          slot <= TAP_IDX_W'(MAX_TAPS - 1);
        end else begin
          slot <= slot - 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered <= sat_value;
      clipped  <= sat_clip;
    end
  end

  // Coefficient store
  always_ff @(posedge clk) begin
    if (accept_load && (int'(tap_index) < MAX_TAPS)) begin
      coef_mem[TAP_IDX_W'(tap_index)] <= tap_value;
    end
    coef_q <= coef_mem[tap_cnt[TAP_IDX_W-1:0]];
  end

  // History store
  always_ff @(posedge clk) begin
    if (accept_sample) begin
      hist_mem[new_slot] <= sample;
    end
    hist_q    <= hist_mem[slot];
    hist_ok_q <= hist_ok[slot];
  end

  assign mac_a = hist_ok_q ? hist_q : '0;

  firlt_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (mac_a),
    .b    (coef_q),
    .acc  (acc),
    .busy (mac_busy)
  );

  firlt_sat u_sat (
    .acc      (acc),
    .filtered (sat_value),
    .clipped  (sat_clip)
  );

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!rd_vld && !mac_busy))
    else $error("pipeline busy while accepting");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (tap_cnt <= n_taps))
    else $error("tap counter beyond tap count");

  a_sample_runs: assert property (@(posedge clk) disable iff (rst)
    accept_sample |=> (state == S_RUN))
    else $error("sample transaction did not start the sequence");

  a_load_once: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == S_DRAIN && !rd_vld && !mac_busy))
    else $error("result loaded before accumulation finished");

endmodule
